// ----- sv/bfa_pkg.sv -----
// Shared constants, codes and helper functions of the bitmap block allocator.
package bfa_pkg;

  localparam int MAX_BLOCKS_DEF = 4096;
  localparam int WORD_W         = 32;
  localparam int BIT_W          = 5;

  localparam int CMD_W       = 2;
  localparam int BLOCK_W     = 12;
  localparam int COUNT_W     = 13;
  localparam int BYTE_IDX_W  = 9;
  localparam int BYTE_W      = 8;
  localparam int STATUS_W    = 2;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  localparam logic [CMD_W-1:0] CMD_ALLOCATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_ZERO = 2'd2;

  localparam logic             REG_BLOCK_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] COUNT_RESET   = 13'd4096;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } ff_t;

  function automatic ff_t find_first(input logic [WORD_W-1:0] vec);
    ff_t res;
    res.found = 1'b0;
    res.idx   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (vec[b]) begin
        res.found = 1'b1;
        res.idx   = BIT_W'(b);
      end
    end
    return res;
  endfunction

  function automatic logic [BYTE_W-1:0] reverse_byte(input logic [BYTE_W-1:0] v);
    logic [BYTE_W-1:0] r;
    for (int k = 0; k < BYTE_W; k++) begin
      r[k] = v[BYTE_W-1-k];
    end
    return r;
  endfunction

endpackage

// ----- sv/bfa_bitmap_ram.sv -----
// Single-port-write, single-port-read bitmap word memory with registered read data.
module bfa_bitmap_ram #(
  parameter int DEPTH = bfa_pkg::MAX_BLOCKS_DEF / bfa_pkg::WORD_W,
  parameter int AW    = 7
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bfa_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [bfa_pkg::WORD_W-1:0] rdata
);

  logic [bfa_pkg::WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/bfa_cfg_regs.sv -----
// APB configuration register holding the volume block count.
module bfa_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bfa_pkg::APB_AW-1:0]  paddr,
  input  logic [bfa_pkg::APB_DW-1:0]  pwdata,
  output logic [bfa_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [bfa_pkg::COUNT_W-1:0] block_count
);

  logic [bfa_pkg::COUNT_W-1:0] count_r;
  logic                        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel && penable && pwrite && (paddr[2] == bfa_pkg::REG_BLOCK_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= bfa_pkg::COUNT_RESET;
    end else if (wr_hit) begin
      count_r <= pwdata[bfa_pkg::COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == bfa_pkg::REG_BLOCK_COUNT) begin
      prdata = bfa_pkg::APB_DW'(count_r);
    end
  end

  assign block_count = count_r;

endmodule

// ----- sv/bitmap_first_fit_block_allocator.sv -----
// Bitmap first-fit block allocator: command sequencer around a 32-bit-word bitmap memory.
// The in-use bitmap lives in one memory of ceil(MAX_BLOCKS/32) words of 32 bits. After
// reset a clearing pass writes every word to zero, one word a cycle, with in_stall high;
// configuration writes are taken during it. One command is worked on at a time. Free and
// load do a read-modify-write of one word; a free of block zero, command 3, a free or
// load beyond the store and an allocate with a block count of 0 or 1 skip that step.
// Allocate scans the memory one word a cycle from word 0. The result sits in an output
// register, so a new command is taken while an earlier result still waits on out_stall.
module bitmap_first_fit_block_allocator #(
  parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bfa_pkg::CMD_W-1:0]      in_command,
  input  logic [bfa_pkg::BLOCK_W-1:0]    in_block_address,
  input  logic [bfa_pkg::BYTE_IDX_W-1:0] in_load_byte_index,
  input  logic [bfa_pkg::BYTE_W-1:0]     in_load_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bfa_pkg::BLOCK_W-1:0]    out_allocated_block,
  output logic [bfa_pkg::STATUS_W-1:0]   out_status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bfa_pkg::APB_AW-1:0]     paddr,
  input  logic [bfa_pkg::APB_DW-1:0]     pwdata,
  output logic [bfa_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  localparam int WW     = bfa_pkg::WORD_W;
  localparam int BW     = bfa_pkg::BIT_W;
  localparam int NWORDS = (MAX_BLOCKS + WW - 1) / WW;
  localparam int WI_W   = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int LW     = $clog2(MAX_BLOCKS + 1);
  localparam int XW     = (((WI_W + BW) > LW) ? (WI_W + BW) : LW) + 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_RESP = 3'd3;

  logic [2:0]                         state_r, state_nxt;
  logic [WI_W-1:0]                    word_r, word_nxt;
  logic [bfa_pkg::CMD_W-1:0]          cmd_r, cmd_nxt;
  logic [WW-1:0]                      mask_r, mask_nxt;
  logic [WW-1:0]                      val_r, val_nxt;
  logic [LW-1:0]                      limit_r, limit_nxt;
  logic [bfa_pkg::BLOCK_W-1:0]        res_block_r, res_block_nxt;
  logic [bfa_pkg::STATUS_W-1:0]       res_status_r, res_status_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [bfa_pkg::BLOCK_W-1:0]        out_block_r, out_block_nxt;
  logic [bfa_pkg::STATUS_W-1:0]       out_status_r, out_status_nxt;

  logic [bfa_pkg::COUNT_W-1:0]        block_count;
  logic                               in_xfer;
  logic                               out_free;
  logic [LW-1:0]                      in_limit;
  logic [BW-1:0]                      in_shift;
  logic                               free_in_range;
  logic                               load_in_range;
  logic [WW-1:0]                      rdata;
  logic                               mem_we, mem_re;
  logic [WI_W-1:0]                    mem_raddr;
  logic [WW-1:0]                      mem_wdata;
  logic [WW-1:0]                      wr_mask, wr_val;
  logic [XW-1:0]                      base_x, lim_x, rem_x;
  logic [WW-1:0]                      allowed;
  logic                               more;
  bfa_pkg::ff_t                       ff;

  bfa_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .block_count (block_count)
  );

  bfa_bitmap_ram #(
    .DEPTH (NWORDS),
    .AW    (WI_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (word_r),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign in_limit = (32'(block_count) > 32'(MAX_BLOCKS)) ? LW'(MAX_BLOCKS) : LW'(block_count);
  assign in_shift = {in_load_byte_index[1:0], 3'b000};
  assign free_in_range = 32'(in_block_address[bfa_pkg::BLOCK_W-1:BW]) < 32'(NWORDS);
  assign load_in_range = 32'(in_load_byte_index[bfa_pkg::BYTE_IDX_W-1:2]) < 32'(NWORDS);

  // scan window of the current word
  assign base_x = XW'({word_r, {BW{1'b0}}});
  assign lim_x  = XW'(limit_r);
  assign rem_x  = lim_x - base_x;
  assign more   = (base_x + XW'(WW)) < lim_x;

  always_comb begin
    for (int b = 0; b < WW; b++) begin
      allowed[b] = XW'(b) < rem_x;
    end
    if (word_r == '0) begin
      allowed[0] = 1'b0;
    end
  end

  assign ff = bfa_pkg::find_first(~rdata & allowed);

  always_comb begin
    if (cmd_r == bfa_pkg::CMD_ALLOCATE) begin
      wr_mask = WW'(1) << ff.idx;
      wr_val  = '1;
    end else begin
      wr_mask = mask_r;
      wr_val  = val_r;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = (rdata & ~wr_mask) | (wr_val & wr_mask);
    mem_re    = 1'b0;
    mem_raddr = word_r + WI_W'(1);
    if (state_r == S_CLR) begin
      mem_we    = 1'b1;
      mem_wdata = '0;
    end else if (state_r == S_MOD) begin
      mem_we = (cmd_r != bfa_pkg::CMD_ALLOCATE) || ff.found;
      mem_re = (cmd_r == bfa_pkg::CMD_ALLOCATE) && !ff.found && more;
    end
    if (in_xfer) begin
      mem_re = 1'b1;
      priority if (in_command == bfa_pkg::CMD_FREE) begin
        mem_raddr = WI_W'(in_block_address[bfa_pkg::BLOCK_W-1:BW]);
      end else if (in_command == bfa_pkg::CMD_LOAD) begin
        mem_raddr = WI_W'(in_load_byte_index[bfa_pkg::BYTE_IDX_W-1:2]);
      end else begin
        mem_raddr = '0;
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    word_nxt       = word_r;
    cmd_nxt        = cmd_r;
    mask_nxt       = mask_r;
    val_nxt        = val_r;
    limit_nxt      = limit_r;
    res_block_nxt  = res_block_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_block_nxt  = out_block_r;
    out_status_nxt = out_status_r;
    unique case (state_r)
      S_CLR: begin
        word_nxt = word_r + WI_W'(1);
        if (word_r == WI_W'(NWORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer) begin
          cmd_nxt        = in_command;
          limit_nxt      = in_limit;
          res_block_nxt  = '0;
          res_status_nxt = bfa_pkg::ST_DONE;
          state_nxt      = S_RESP;
          unique case (in_command)
            bfa_pkg::CMD_ALLOCATE: begin
              word_nxt = '0;
              if (32'(in_limit) <= 32'd1) begin
                res_status_nxt = bfa_pkg::ST_NO_SPACE;
              end else begin
                state_nxt = S_MOD;
              end
            end
            bfa_pkg::CMD_FREE: begin
              word_nxt = WI_W'(in_block_address[bfa_pkg::BLOCK_W-1:BW]);
              mask_nxt = WW'(1) << in_block_address[BW-1:0];
              val_nxt  = '0;
              if (in_block_address == '0) begin
                res_status_nxt = bfa_pkg::ST_FREE_ZERO;
              end else if (free_in_range) begin
                state_nxt = S_MOD;
              end
            end
            bfa_pkg::CMD_LOAD: begin
              word_nxt = WI_W'(in_load_byte_index[bfa_pkg::BYTE_IDX_W-1:2]);
              mask_nxt = WW'({bfa_pkg::BYTE_W{1'b1}}) << in_shift;
              val_nxt  = WW'(bfa_pkg::reverse_byte(in_load_byte)) << in_shift;
              if (load_in_range) begin
                state_nxt = S_MOD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_MOD: begin
        if (cmd_r != bfa_pkg::CMD_ALLOCATE) begin
          state_nxt = S_RESP;
        end else if (ff.found) begin
          res_block_nxt = bfa_pkg::BLOCK_W'(base_x + XW'(ff.idx));
          state_nxt     = S_RESP;
        end else if (more) begin
          word_nxt = word_r + WI_W'(1);
        end else begin
          res_status_nxt = bfa_pkg::ST_NO_SPACE;
          state_nxt      = S_RESP;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_block_nxt  = res_block_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      word_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      word_r      <= word_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    mask_r       <= mask_nxt;
    val_r        <= val_nxt;
    limit_r      <= limit_nxt;
    res_block_r  <= res_block_nxt;
    res_status_r <= res_status_nxt;
    out_block_r  <= out_block_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_allocated_block = out_block_r;
  assign out_status          = out_status_r;

endmodule

// ----- sv/bfa_checker.sv -----
// Port-level checker of the bitmap block allocator and its bind to the top level.
module bfa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [bfa_pkg::BLOCK_W-1:0]    out_allocated_block,
  input logic [bfa_pkg::STATUS_W-1:0]   out_status
);

  // clearing pass holds off commands and no result is pending out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("busy or result pending right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_allocated_block) && $stable(out_status))
    else $error("stalled result transfer changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != bfa_pkg::ST_DONE) |-> out_allocated_block == '0)
    else $error("failed command returned a block number");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == bfa_pkg::ST_DONE) || (out_status == bfa_pkg::ST_NO_SPACE) ||
                  (out_status == bfa_pkg::ST_FREE_ZERO))
    else $error("undefined status code");

endmodule

bind bitmap_first_fit_block_allocator bfa_checker u_bfa_checker (.*);
